@@ rtl/kvst_pkg.sv @@
// ----------------------------------------------------------------------------
// kvst_pkg: shared types for the key/value slot table
// Request and status codes, the token that walks the cell chain, the
// commit bus that writes one slot, and the string cut helper.
// ----------------------------------------------------------------------------
package kvst_pkg;

   localparam int TEXT_W  = 56;   // packed string, seven bytes
   localparam int TEXT_B  = 7;
   localparam int IDX_W   = 8;    // enough for 256 slots
   localparam int CFG_W   = 5;
   localparam int CMP_W   = 9;    // slot index vs slot count compare
   localparam int SLOT_OUT_W = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_SEARCH = 2'd0,
      OP_INSERT = 2'd1,
      OP_UPDATE = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_FULL      = 3'd3,
      ST_INVALID   = 3'd4
   } status_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [TEXT_W-1:0] key;
      logic [TEXT_W-1:0] req_value;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [TEXT_W-1:0] hit_value;
      logic              free;
      logic [IDX_W-1:0]  free_idx;
   } token_type;

   typedef struct packed {
      logic              wr_key;
      logic              wr_val;
      logic [IDX_W-1:0]  idx;
      logic [TEXT_W-1:0] key;
      logic [TEXT_W-1:0] value;
   } commit_type;

   // Keep at most nbytes bytes, up to the first zero byte.
   function automatic logic [TEXT_W-1:0] canon(input logic [TEXT_W-1:0] s,
                                               input int unsigned nbytes);
      logic [TEXT_W-1:0] r;
      logic              stop;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < TEXT_B; i++) begin
         if (i >= nbytes || s[8*i +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            r[8*i +: 8] = s[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/kvst_if.sv @@
// ----------------------------------------------------------------------------
// kvst_if: channel interfaces of the key/value slot table
// Request, response and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface kvst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [55:0] key_text;
   logic [55:0] value_text;
   modport source (output valid, req_type, key_text, value_text, input ready);
   modport sink   (input valid, req_type, key_text, value_text, output ready);
endinterface

interface kvst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [55:0] value_out;
   logic [3:0]  slot_index;
   modport source (output valid, status, value_out, slot_index, input ready);
   modport sink   (input valid, status, value_out, slot_index, output ready);
endinterface

interface kvst_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] slots_in_use;
   modport source (output valid, slots_in_use, input ready);
   modport sink   (input valid, slots_in_use, output ready);
endinterface

@@ rtl/key_value_slot_table.sv @@
// ----------------------------------------------------------------------------
// key_value_slot_table: associative key/value table of fixed slots
// Order: the token walks the cell chain one cell per cycle from request
//   transfer (an empty key skips it); the result then waits for the output.
// Requests: a new one is taken only after the last response is handed over.
// Reset: every key cleared (all slots free), slots_in_use back to 16.
// ----------------------------------------------------------------------------
module key_value_slot_table #(
   parameter int SLOTS       = 16,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic          clock,
   input  logic          reset,
   kvst_req_if.sink      req,
   kvst_rsp_if.source    rsp,
   kvst_csr_if.sink      csr
);

   localparam int KEY_W   = 8 * (KEY_BYTES - 1);
   localparam int VALUE_W = 8 * (VALUE_BYTES - 1);
   localparam int TW      = kvst_pkg::TEXT_W;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DONE
   } state_type;

   state_type                        state_ff;
   logic [kvst_pkg::CFG_W-1:0]       slots_ff;
   logic                             rsp_valid_ff;
   kvst_pkg::status_type             rsp_status_ff;
   logic [TW-1:0]                    rsp_value_ff;
   logic [kvst_pkg::SLOT_OUT_W-1:0]  rsp_slot_ff;
   kvst_pkg::status_type             pend_status_ff;
   logic [TW-1:0]                    pend_value_ff;
   logic [kvst_pkg::SLOT_OUT_W-1:0]  pend_slot_ff;

   kvst_pkg::token_type              tok [SLOTS+1];
   kvst_pkg::token_type              head;
   kvst_pkg::token_type              tail;
   kvst_pkg::commit_type             commit;
   kvst_pkg::status_type             res_status;
   logic [TW-1:0]                    res_value;
   logic [kvst_pkg::IDX_W-1:0]       res_idx;
   logic [TW-1:0]                    key_c;
   logic [TW-1:0]                    val_c;
   logic                             req_xfer;

   assign key_c    = kvst_pkg::canon(req.key_text, (KEY_BYTES - 1));
   assign val_c    = kvst_pkg::canon(req.value_text, (VALUE_BYTES - 1));
   assign req.ready = state_ff == IDLE;
   assign req_xfer = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      head           = '0;
      head.valid     = req_xfer && (key_c != '0);
      head.op        = kvst_pkg::op_type'(req.req_type);
      head.key       = key_c;
      head.req_value = val_c;
   end

   assign tok[0] = head;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      kvst_cell #(
         .INDEX   (i),
         .KEY_W   (KEY_W),
         .VALUE_W (VALUE_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .slots_in_use (slots_ff),
         .up_tok       (tok[i]),
         .dn_tok       (tok[i+1]),
         .commit       (commit)
      );
   end

   assign tail = tok[SLOTS];

   // Decide the result and the slot write as the token leaves the chain.
   always_comb begin
      commit     = '0;
      res_status = kvst_pkg::ST_OK;
      res_value  = '0;
      res_idx    = '0;
      unique case (tail.op)
         kvst_pkg::OP_SEARCH: begin
            if (tail.hit) begin
               res_value = tail.hit_value;
               res_idx   = tail.hit_idx;
            end else begin
               res_status = kvst_pkg::ST_NOT_FOUND;
            end
         end
         kvst_pkg::OP_INSERT: begin
            if (tail.hit) begin
               res_status = kvst_pkg::ST_EXISTS;
            end else if (tail.free) begin
               commit.wr_key = 1'b1;
               commit.wr_val = 1'b1;
               commit.idx    = tail.free_idx;
               commit.key    = tail.key;
               commit.value  = tail.req_value;
               res_idx       = tail.free_idx;
            end else begin
               res_status = kvst_pkg::ST_FULL;
            end
         end
         kvst_pkg::OP_UPDATE: begin
            if (tail.hit) begin
               commit.wr_val = 1'b1;
               commit.idx    = tail.hit_idx;
               commit.value  = tail.req_value;
               res_idx       = tail.hit_idx;
            end else begin
               res_status = kvst_pkg::ST_NOT_FOUND;
            end
         end
         kvst_pkg::OP_DELETE: begin
            if (tail.hit) begin
               // both key and value go back to zero
               commit.wr_key = 1'b1;
               commit.wr_val = 1'b1;
               commit.idx    = tail.hit_idx;
               res_idx       = tail.hit_idx;
            end else begin
               res_status = kvst_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            res_status = kvst_pkg::ST_NOT_FOUND;
         end
      endcase
      if (!tail.valid) begin
         commit = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         slots_ff     <= kvst_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            slots_ff <= csr.slots_in_use;
         end
         // in DONE the output register is reloaded instead
         if (rsp_valid_ff && rsp.ready && state_ff != DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_xfer) begin
                  if (key_c == '0) begin
                     pend_status_ff <= kvst_pkg::ST_INVALID;
                     pend_value_ff  <= '0;
                     pend_slot_ff   <= '0;
                     state_ff       <= DONE;
                  end else begin
                     state_ff <= SCAN;
                  end
               end
            end
            SCAN: begin
               if (tail.valid) begin
                  pend_status_ff <= res_status;
                  pend_value_ff  <= res_value;
                  pend_slot_ff   <= res_idx[kvst_pkg::SLOT_OUT_W-1:0];
                  state_ff       <= DONE;
               end
            end
            DONE: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pend_status_ff;
                  rsp_value_ff  <= pend_value_ff;
                  rsp_slot_ff   <= pend_slot_ff;
                  state_ff      <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.value_out  = rsp_value_ff;
   assign rsp.slot_index = rsp_slot_ff;

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> state_ff == SCAN)
      else $error("token left chain outside scan");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      !(head.valid && tail.valid))
      else $error("two tokens in chain");

   a_commit_gated: assert property (@(posedge clock) disable iff (reset)
      (commit.wr_key || commit.wr_val) |-> tail.valid)
      else $error("slot write without token");

   a_scan_to_done: assert property (@(posedge clock) disable iff (reset)
      tail.valid |=> state_ff == DONE)
      else $error("result not captured");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != kvst_pkg::ST_OK)
         |-> (rsp_value_ff == '0 && rsp_slot_ff == '0))
      else $error("failed response carries data");

endmodule

@@ rtl/kvst_cell.sv @@
// ----------------------------------------------------------------------------
// kvst_cell: one slot of the table
// Holds one key and value. The search token passes through once a cycle;
// the cell marks the first key hit and the first free slot on it.
// ----------------------------------------------------------------------------
module kvst_cell #(
   parameter int INDEX   = 0,
   parameter int KEY_W   = 56,
   parameter int VALUE_W = 56
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [kvst_pkg::CFG_W-1:0]          slots_in_use,
   input  kvst_pkg::token_type                 up_tok,
   output kvst_pkg::token_type                 dn_tok,
   input  kvst_pkg::commit_type                commit
);

   localparam int TW = kvst_pkg::TEXT_W;
   localparam int IW = kvst_pkg::IDX_W;
   localparam int CW = kvst_pkg::CMP_W;
   localparam logic [IW-1:0] SELF = IW'(INDEX);

   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;
   kvst_pkg::token_type tok_ff;
   kvst_pkg::token_type tok_in;
   logic                in_use;
   logic                match;
   logic                empty;
   logic                sel;

   assign in_use = CW'(INDEX) < CW'(slots_in_use);
   assign match  = up_tok.valid && in_use && (TW'(key_ff) == up_tok.key);
   assign empty  = up_tok.valid && in_use && (key_ff == '0);
   assign sel    = commit.idx == SELF;

   always_comb begin
      tok_in = up_tok;
      if (match && !up_tok.hit) begin
         tok_in.hit       = 1'b1;
         tok_in.hit_idx   = SELF;
         tok_in.hit_value = TW'(value_ff);
      end
      if (empty && !up_tok.free) begin
         tok_in.free     = 1'b1;
         tok_in.free_idx = SELF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         key_ff <= '0;
      end else begin
         tok_ff <= tok_in;
         if (commit.wr_key && sel) begin
            key_ff <= commit.key[KEY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit.wr_val && sel) begin
         value_ff <= commit.value[VALUE_W-1:0];
      end
   end

   assign dn_tok = tok_ff;

endmodule
